// File: hw/rtl/fwrbk_pkg.sv
// Shared types and constants for the FIFO with remove-by-key.
`timescale 1ns / 1ps

package fwrbk_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 16;
    localparam int KEY_W     = 16;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_REM = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]       operation;
        logic [ID_W-1:0]  item_id;
        logic [KEY_W-1:0] item_key;
    } t_req;

    typedef struct packed {
        logic                 ok;
        logic [ID_W-1:0]      out_id;
        logic [KEY_W-1:0]     out_key;
        logic [CNT_OUT_W-1:0] count;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic cap;      // latch key, clear index and dequeue outputs
        logic enq;      // write new entry at tail, count up
        logic rd_idx;   // read slot at index
        logic rd_next;  // read slot at index + 1
        logic idx_inc;
        logic wr_shift; // write last read entry into slot at index
        logic cap_out;  // keep last read entry as dequeue result
        logic dec;      // count down
        logic done;     // emit result beat
        logic ok;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic last;     // index + 1 reaches the count
    } t_sts;

endpackage

// File: hw/rtl/fifo_with_remove_by_key_unit.sv
// Top level of the FIFO with remove-by-key: sequencer plus datapath.
`timescale 1ns / 1ps

//  channel  | handshake         | payload        | notes
//  ---------+-------------------+----------------+------------------------------
//  command  | start / busy      | i_item (t_req) | beat taken when start && !busy
//  result   | o_valid (strobe)  | o_result       | one cycle, one beat per command
//
// Enqueue, an unused opcode, and a dequeue or remove on an empty queue finish
// at the accept edge; busy stays low and the result strobe follows in the next
// cycle, so these can go back to back. A dequeue or remove on a non-empty
// queue walks the entry memory through its single read port: a read and a
// compare step per slot searched up to the hit, then a read and a write step
// per slot moved up plus a final step to finish; busy stays high until then,
// and the strobe comes in the same cycle that busy drops. Synchronous
// active-low reset empties the queue; the entry memory is not cleared. Results cannot be stalled.

module fifo_with_remove_by_key_unit
    import fwrbk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_item,
    output logic o_valid,
    output t_rsp o_result
);

    t_cmd cmd;
    t_sts sts;
    logic accept;

    // a beat is taken only while the sequencer sits idle
    assign accept = start && !busy;

    fwrbk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_item.operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    fwrbk_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // A failed command never reports entry data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.ok |-> (o_result.out_id == '0) && (o_result.out_key == '0))
        else $error("failed command returned entry data");

    // An enqueue completes at its accept edge and never makes the block busy.
    a_enq_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.operation == OP_ENQ) |=> !busy && o_valid)
        else $error("enqueue did not finish in one cycle");

    // When a multi-cycle command starts, no stale result is on the strobe.
    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_valid)
        else $error("result strobe at start of busy period");

    // A result is only produced by the command in progress.
    a_valid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept) || $past(busy))
        else $error("result strobe without a command");

endmodule

// File: hw/rtl/fwrbk_ctrl.sv
// Sequencer for the FIFO with remove-by-key: search and compaction steps.
`timescale 1ns / 1ps

module fwrbk_ctrl
    import fwrbk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_operation,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_CMP   = 5'b00100,
        S_SH_RD = 5'b01000,
        S_SH_WR = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_deq, n_is_deq;

    always_comb begin
        n_state  = r_state;
        n_is_deq = r_is_deq;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.cap = 1'b1;
                    n_is_deq  = (i_operation == OP_DEQ);
                    case (i_operation)
                        OP_ENQ: begin
                            o_cmd.done = 1'b1;
                            o_cmd.ok   = !i_sts.full;
                            o_cmd.enq  = !i_sts.full;
                        end
                        OP_DEQ, OP_REM: begin
                            if (i_sts.empty) begin
                                o_cmd.done = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            o_cmd.done = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (r_is_deq || i_sts.match) begin
                    o_cmd.cap_out = r_is_deq;
                    n_state       = S_SH_RD;
                end else if (i_sts.last) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.last) begin
                    o_cmd.dec  = 1'b1;
                    o_cmd.done = 1'b1;
                    o_cmd.ok   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SH_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_is_deq <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_deq <= n_is_deq;
        end
    end

endmodule

// File: hw/rtl/fwrbk_dp.sv
// Datapath for the FIFO with remove-by-key: entry memory, count, index, result.
`timescale 1ns / 1ps

module fwrbk_dp
    import fwrbk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_item,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_valid,
    output t_rsp o_result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx;
    logic [KEY_W-1:0] r_key;
    logic [ID_W-1:0]  r_out_id, n_out_id;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic             r_valid;
    t_rsp             r_res;

    logic [CW:0]   idx_p1;
    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    t_entry        wr_data;

    assign idx_p1 = {1'b0, r_idx} + (CW + 1)'(1);

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(DEPTH));
    assign o_sts.match = (r_rd_data.key == r_key);
    assign o_sts.last  = (idx_p1 >= {1'b0, r_count});

    // single read port, registered data
    assign rd_addr = i_cmd.rd_next ? idx_p1[IW-1:0] : r_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_idx || i_cmd.rd_next) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // single write port: tail on enqueue, compaction otherwise
    assign wr_en   = i_cmd.enq || i_cmd.wr_shift;
    assign wr_addr = i_cmd.enq ? r_count[IW-1:0] : r_idx[IW-1:0];

    always_comb begin
        wr_data = r_rd_data;
        if (i_cmd.enq) begin
            wr_data.id  = i_item.item_id;
            wr_data.key = i_item.item_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.enq) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out_id  = r_out_id;
        n_out_key = r_out_key;
        if (i_cmd.cap) begin
            n_out_id  = '0;
            n_out_key = '0;
        end else if (i_cmd.cap_out) begin
            n_out_id  = r_rd_data.id;
            n_out_key = r_rd_data.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.done;
            if (i_cmd.cap) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_id  <= n_out_id;
        r_out_key <= n_out_key;
        if (i_cmd.cap) begin
            r_key <= i_item.item_key;
        end
        if (i_cmd.done) begin
            r_res.ok      <= i_cmd.ok;
            r_res.out_id  <= n_out_id;
            r_res.out_key <= n_out_key;
            r_res.count   <= CNT_OUT_W'(n_count);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule
